[src/awed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awed_pkg: shared types and constants of the window event detector
// item kinds, event codes, register indexes, field widths and reset values
// ----------------------------------------------------------------------------
package awed_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 17;
    localparam int LIMIT_W   = 16;
    localparam int PERIOD_W  = 8;
    localparam int EVBITS_W  = 5;
    localparam int EVCODE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    // item kind carried in tuser
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    // classification of one evaluation
    typedef enum logic [EVCODE_W-1:0] {
        EV_NONE    = 3'd0,
        EV_ACCEL   = 3'd1,
        EV_DECEL   = 3'd2,
        EV_LEFT    = 3'd3,
        EV_RIGHT   = 3'd4,
        EV_POTHOLE = 3'd5
    } t_event;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SLOPE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SLOPE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SLOPE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SLOPE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STDEV_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PERIOD  = 3'd5;

    // register reset values
    localparam longint RST_Y_SLOPE_HIGH  = 400;
    localparam longint RST_Y_SLOPE_LOW   = -400;
    localparam longint RST_Z_SLOPE_HIGH  = 250;
    localparam longint RST_Z_SLOPE_LOW   = -250;
    localparam longint RST_X_STDEV_LIMIT = 1800;
    localparam logic [PERIOD_W-1:0] RST_CLEAR_PERIOD = 8'd10;

endpackage : awed_pkg
`default_nettype wire

[src/awed_window_sums.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awed_window_sums: sliding sample window with running sums
// ring memory of x/y/z samples, updates sums, index-weighted sums and x^2 sum
// ----------------------------------------------------------------------------
module awed_window_sums
    import awed_pkg::*;
#(
    parameter int WINDOW = 32,
    localparam int PTR_W  = $clog2(WINDOW),
    localparam int SI     = WINDOW * (WINDOW + 1) / 2,
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW) + 1,
    localparam int WSUM_W = SAMPLE_W + $clog2(SI) + 1,
    localparam int SQ_W   = 2 * SAMPLE_W + $clog2(WINDOW) - 1
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire  signed [SAMPLE_W-1:0] i_x,
    input  wire  signed [SAMPLE_W-1:0] i_y,
    input  wire  signed [SAMPLE_W-1:0] i_z,
    output logic signed [SUM_W-1:0]    o_sum_x,
    output logic signed [SUM_W-1:0]    o_sum_y,
    output logic signed [SUM_W-1:0]    o_sum_z,
    output logic signed [WSUM_W-1:0]   o_wsum_y,
    output logic signed [WSUM_W-1:0]   o_wsum_z,
    output logic        [SQ_W-1:0]     o_sqsum_x
);

    localparam logic [PTR_W-1:0]         PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic signed [WSUM_W-1:0] K_N      = WSUM_W'(WINDOW);

    logic [3*SAMPLE_W-1:0] mem [WINDOW];
    logic [3*SAMPLE_W-1:0] r_rd;

    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic             r_full;

    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y, r_sum_z;
    logic signed [WSUM_W-1:0]   r_wsum_y, r_wsum_z;
    logic        [SQ_W-1:0]     r_sqsum_x;

    logic signed [SAMPLE_W-1:0]   old_x, old_y, old_z;
    logic signed [2*SAMPLE_W-1:0] sq_new, sq_old;

    // read ahead at the next slot, so the oldest sample is ready at push time
    always_comb begin
        n_ptr = r_ptr;
        if (i_push) begin
            n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_ptr] <= {i_z, i_y, i_x};
        end
        r_rd <= mem[n_ptr];
    end

    // slots never written read as zero until the ring has wrapped once
    always_comb begin
        old_x = '0;
        old_y = '0;
        old_z = '0;
        if (r_full) begin
            old_x = $signed(r_rd[SAMPLE_W-1:0]);
            old_y = $signed(r_rd[2*SAMPLE_W-1:SAMPLE_W]);
            old_z = $signed(r_rd[3*SAMPLE_W-1:2*SAMPLE_W]);
        end
    end

    assign sq_new = i_x * i_x;
    assign sq_old = old_x * old_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_full    <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_z   <= '0;
            r_wsum_y  <= '0;
            r_wsum_z  <= '0;
            r_sqsum_x <= '0;
        end else if (i_push) begin
            r_ptr     <= n_ptr;
            if (r_ptr == PTR_LAST) begin
                r_full <= 1'b1;
            end
            r_sum_x   <= r_sum_x - SUM_W'(old_x) + SUM_W'(i_x);
            r_sum_y   <= r_sum_y - SUM_W'(old_y) + SUM_W'(i_y);
            r_sum_z   <= r_sum_z - SUM_W'(old_z) + SUM_W'(i_z);
            // shifting every index down by one takes off the plain sum
            r_wsum_y  <= r_wsum_y - WSUM_W'(r_sum_y) + K_N * WSUM_W'(i_y);
            r_wsum_z  <= r_wsum_z - WSUM_W'(r_sum_z) + K_N * WSUM_W'(i_z);
            r_sqsum_x <= r_sqsum_x - SQ_W'($unsigned(sq_old)) + SQ_W'($unsigned(sq_new));
        end
    end

    assign o_sum_x   = r_sum_x;
    assign o_sum_y   = r_sum_y;
    assign o_sum_z   = r_sum_z;
    assign o_wsum_y  = r_wsum_y;
    assign o_wsum_z  = r_wsum_z;
    assign o_sqsum_x = r_sqsum_x;

endmodule : awed_window_sums
`default_nettype wire

[src/accel_window_event_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_window_event_detector: accelerometer window event detector
// pushes x/y/z samples into sliding windows and classifies evaluations by
// least-squares slope of y and z and the sample standard deviation of x
// ----------------------------------------------------------------------------
//
// channel   direction  tdata (low bit up)                    tuser
// s_axis    in         sample_x[15:0] y[31:16] z[47:32]     op (0 push, 1 eval)
// m_axis    out        event_bits[4:0] event_now[7:5]       -
// cfg       in         i_cfg_idx selects, i_cfg_wdata value  -
//
// one item per cycle unless m_axis stalls an evaluation: an accepted item is held in
// the input register, then a push updates the window sums and an evaluation loads
// the result register; a new item is accepted as the held one drains
// push items never produce a result transfer
// synchronous active-low reset clears the sums, pointer, sticky bits and counter
// a stalled m_axis holds an evaluation in the input register and every item
// behind it; pushes ahead of that evaluation keep flowing
//
module accel_window_event_detector
    import awed_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // sample / evaluate stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [47:0]          s_axis_tdata,   // sample_x, sample_y, sample_z
    input  wire                  s_axis_tuser,   // op
    // result stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // event_bits, event_now
    // configuration writes
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [CFG_DAT_W-1:0] i_cfg_wdata
);

    // window arithmetic widths and constants
    localparam int SI     = WINDOW * (WINDOW + 1) / 2;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int WSUM_W = SAMPLE_W + $clog2(SI) + 1;
    localparam int SQ_W   = 2 * SAMPLE_W + $clog2(WINDOW) - 1;
    localparam int CB     = $clog2(WINDOW + 1);
    localparam int CMP_A  = 18 + 4 * CB;
    localparam int CMP_B  = 34 + 2 * CB;
    localparam int CMP_W  = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    localparam longint N_L   = WINDOW;
    localparam longint SI_L  = N_L * (N_L + 1) / 2;
    localparam longint SII_L = N_L * (N_L + 1) * (2 * N_L + 1) / 6;
    localparam longint D_L   = N_L * SII_L - SI_L * SI_L;
    localparam longint NN1_L = N_L * (N_L - 1);

    localparam logic signed [CMP_W-1:0] K_N   = CMP_W'(N_L);
    localparam logic signed [CMP_W-1:0] K_SI  = CMP_W'(SI_L);
    localparam logic signed [CMP_W-1:0] K_D   = CMP_W'(D_L);
    localparam logic signed [CMP_W-1:0] K_NN1 = CMP_W'(NN1_L);

    // thresholds are kept already scaled by the slope denominator
    localparam logic signed [CMP_W-1:0] RST_YH = CMP_W'(RST_Y_SLOPE_HIGH * D_L);
    localparam logic signed [CMP_W-1:0] RST_YL = CMP_W'(RST_Y_SLOPE_LOW * D_L);
    localparam logic signed [CMP_W-1:0] RST_ZH = CMP_W'(RST_Z_SLOPE_HIGH * D_L);
    localparam logic signed [CMP_W-1:0] RST_ZL = CMP_W'(RST_Z_SLOPE_LOW * D_L);
    localparam logic signed [CMP_W-1:0] RST_LIM =
        CMP_W'(RST_X_STDEV_LIMIT * RST_X_STDEV_LIMIT * NN1_L);

    // ---------------------------------------------------------------- config
    logic signed [CMP_W-1:0] r_yh, r_yl, r_zh, r_zl, r_lim;
    logic [PERIOD_W-1:0]     r_period;

    logic signed [THR_W-1:0]     cfg_thr;
    logic signed [CMP_W-1:0]     cfg_thr_d;
    logic [2*LIMIT_W-1:0]        cfg_lim_sq;
    logic signed [CMP_W-1:0]     cfg_lim;

    assign cfg_thr    = $signed(i_cfg_wdata[THR_W-1:0]);
    assign cfg_thr_d  = K_D * CMP_W'(cfg_thr);
    assign cfg_lim_sq = i_cfg_wdata[LIMIT_W-1:0] * i_cfg_wdata[LIMIT_W-1:0];
    assign cfg_lim    = K_NN1 * $signed(CMP_W'(cfg_lim_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yh     <= RST_YH;
            r_yl     <= RST_YL;
            r_zh     <= RST_ZH;
            r_zl     <= RST_ZL;
            r_lim    <= RST_LIM;
            r_period <= RST_CLEAR_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_Y_SLOPE_HIGH:  r_yh     <= cfg_thr_d;
                CFG_Y_SLOPE_LOW:   r_yl     <= cfg_thr_d;
                CFG_Z_SLOPE_HIGH:  r_zh     <= cfg_thr_d;
                CFG_Z_SLOPE_LOW:   r_zl     <= cfg_thr_d;
                CFG_X_STDEV_LIMIT: r_lim    <= cfg_lim;
                CFG_CLEAR_PERIOD:  r_period <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------- input stage
    logic                       r_in_valid;
    t_op                        r_in_op;
    logic signed [SAMPLE_W-1:0] r_in_x, r_in_y, r_in_z;

    logic r_out_valid;
    logic in_fire, push_fire, eval_fire;

    // a push always drains; an evaluation waits for room in the result register
    assign in_fire   = r_in_valid &&
                       (r_in_op == OP_PUSH || !r_out_valid || m_axis_tready);
    assign push_fire = in_fire && (r_in_op == OP_PUSH);
    assign eval_fire = in_fire && (r_in_op == OP_EVAL);

    assign s_axis_tready = !r_in_valid || in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op <= t_op'(s_axis_tuser);
            r_in_x  <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
            r_in_y  <= $signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            r_in_z  <= $signed(s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
        end
    end

    // ----------------------------------------------------------- window sums
    logic signed [SUM_W-1:0]  sum_x, sum_y, sum_z;
    logic signed [WSUM_W-1:0] wsum_y, wsum_z;
    logic        [SQ_W-1:0]   sqsum_x;

    awed_window_sums #(
        .WINDOW (WINDOW)
    ) u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_fire),
        .i_x       (r_in_x),
        .i_y       (r_in_y),
        .i_z       (r_in_z),
        .o_sum_x   (sum_x),
        .o_sum_y   (sum_y),
        .o_sum_z   (sum_z),
        .o_wsum_y  (wsum_y),
        .o_wsum_z  (wsum_z),
        .o_sqsum_x (sqsum_x)
    );

    // ------------------------------------------------------- classification
    // slope >= t  <=>  N*Swy - SI*Sy >= t*D
    // stdev >= L  <=>  N*Sxx - Sx^2 >= L^2*N*(N-1)
    logic signed [CMP_W-1:0]   num_y, num_z, var_x;
    logic signed [2*SUM_W-1:0] sx_sq;
    t_event                    ev_now;

    assign num_y = K_N * CMP_W'(wsum_y) - K_SI * CMP_W'(sum_y);
    assign num_z = K_N * CMP_W'(wsum_z) - K_SI * CMP_W'(sum_z);
    assign sx_sq = sum_x * sum_x;
    assign var_x = K_N * $signed(CMP_W'(sqsum_x)) - CMP_W'(sx_sq);

    // priority: accel, decel, left, right, pothole
    always_comb begin
        if (num_y >= r_yh) begin
            ev_now = EV_ACCEL;
        end else if (num_y <= r_yl) begin
            ev_now = EV_DECEL;
        end else if (num_z >= r_zh) begin
            ev_now = EV_LEFT;
        end else if (num_z <= r_zl) begin
            ev_now = EV_RIGHT;
        end else if (var_x >= r_lim) begin
            ev_now = EV_POTHOLE;
        end else begin
            ev_now = EV_NONE;
        end
    end

    // ------------------------------------------------ sticky bits and clearing
    logic [EVBITS_W-1:0] r_sticky, n_sticky, ev_mask, sticky_base;
    logic [PERIOD_W-1:0] r_eval_cnt, n_eval_cnt, cnt_inc, period;

    always_comb begin
        case (ev_now)
            EV_ACCEL:   ev_mask = 5'b00001;
            EV_DECEL:   ev_mask = 5'b00010;
            EV_LEFT:    ev_mask = 5'b00100;
            EV_RIGHT:   ev_mask = 5'b01000;
            EV_POTHOLE: ev_mask = 5'b10000;
            default:    ev_mask = '0;
        endcase
    end

    // zero period behaves as one; a count above a lowered period wraps next time
    assign period      = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign cnt_inc     = r_eval_cnt + 1'b1;
    assign n_eval_cnt  = (cnt_inc >= period) ? '0 : cnt_inc;
    assign sticky_base = (r_eval_cnt == '0) ? '0 : r_sticky;
    assign n_sticky    = sticky_base | ev_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky   <= '0;
            r_eval_cnt <= '0;
        end else if (eval_fire) begin
            r_sticky   <= n_sticky;
            r_eval_cnt <= n_eval_cnt;
        end
    end

    // -------------------------------------------------------- result register
    logic [EVBITS_W-1:0] r_out_bits;
    t_event              r_out_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            r_out_bits <= n_sticky;
            r_out_now  <= ev_now;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_now, r_out_bits};

    // ------------------------------------------------------------- assertions
    // a push into an empty result register leaves it empty
    a_push_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_fire && !r_out_valid) |=> !m_axis_tvalid)
        else $error("push produced a result transfer");

    // an evaluation that clears the sticky bits reports at most its own event
    a_clear_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eval_fire && r_eval_cnt == '0) |=> ($countones(m_axis_tdata[4:0]) <= 1))
        else $error("sticky bits survived a clearing evaluation");

    // a reported event is always reflected in the sticky bits
    a_now_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7:5] != EV_NONE) |-> (m_axis_tdata[4:0] != '0))
        else $error("event reported without sticky bit");

endmodule : accel_window_event_detector
`default_nettype wire
